[rtl/ledd_pkg.sv]
// shared types and constants for the addressable led serial driver
`default_nettype none

package ledd_pkg;

  // default depth of the pixel store
  localparam int MAX_PIXELS_DEF = 256;

  // field widths
  localparam int PIXEL_COUNT_W = 9;
  localparam int TICKS_W       = 8;
  localparam int LATCH_W       = 16;
  localparam int INDEX_W       = 8;
  localparam int CHAN_W        = 8;
  localparam int WORD_W        = 24;
  localparam int BIT_CNT_W     = 5;

  // last bit of a pixel word, sent msb first
  localparam logic [BIT_CNT_W-1:0] LAST_BIT = BIT_CNT_W'(WORD_W - 1);

  // configuration port
  localparam int PADDR_W = 5;
  localparam int PDATA_W = 32;
  localparam int REG_SEL_W = 3;
  localparam logic [REG_SEL_W-1:0] REG_PIXEL_COUNT     = 3'd0;
  localparam logic [REG_SEL_W-1:0] REG_ONE_HIGH_TICKS  = 3'd1;
  localparam logic [REG_SEL_W-1:0] REG_ZERO_HIGH_TICKS = 3'd2;
  localparam logic [REG_SEL_W-1:0] REG_BIT_PERIOD      = 3'd3;
  localparam logic [REG_SEL_W-1:0] REG_LATCH_TICKS     = 3'd4;

  // register reset values
  localparam logic [PIXEL_COUNT_W-1:0] PIXEL_COUNT_RST = 9'd0;
  localparam logic [TICKS_W-1:0]       ONE_HIGH_RST    = 8'd13;
  localparam logic [TICKS_W-1:0]       ZERO_HIGH_RST   = 8'd6;
  localparam logic [TICKS_W-1:0]       BIT_PERIOD_RST  = 8'd20;
  localparam logic [LATCH_W-1:0]       LATCH_RST       = 16'd800;

  // queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = 1;
  localparam int QCNT_W      = 2;

  typedef enum logic [1:0] {
    MODE_IDLE,
    MODE_WAIT,
    MODE_SEND
  } mode_t;

  typedef struct packed {
    logic [PIXEL_COUNT_W-1:0] pixel_count;
    logic [TICKS_W-1:0]       one_high_ticks;
    logic [TICKS_W-1:0]       zero_high_ticks;
    logic [TICKS_W-1:0]       bit_period_ticks;
    logic [LATCH_W-1:0]       latch_ticks;
  } cfg_t;

  // one classified tick as it travels through the queue
  typedef struct packed {
    logic               wr;
    logic [INDEX_W-1:0] index;
    logic [WORD_W-1:0]  grb;
    logic               start;
  } item_t;

endpackage

`default_nettype wire

[rtl/addressable_led_serial_driver.sv]
// top level of the addressable led one-wire serial driver
//
//   channel   direction  handshake            fields
//   in        sink       in_valid / in_stall  write_pixel pixel_index red green blue start_frame
//   out       source     out_valid/out_stall  serial_out busy_res frame_done write_ignored
//   config    apb write  psel penable pwrite  paddr pwdata -> prdata, pready high
//
// one beat in is one waveform tick; a beat is taken every cycle while in_stall is low and,
// with the output free, its result passes through the queue and then the output register.
// after reset the pixel store is swept to zero with in_stall high; register
// writes are taken during the sweep.
// a stalled output holds its beat; the two-entry queue absorbs the stall
// before in_stall rises.
`default_nettype none

module addressable_led_serial_driver #(
  parameter int MAX_PIXELS = ledd_pkg::MAX_PIXELS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [ledd_pkg::PADDR_W-1:0] paddr,
  input  logic [ledd_pkg::PDATA_W-1:0] pwdata,
  output logic [ledd_pkg::PDATA_W-1:0] prdata,
  output logic                         pready,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         write_pixel,
  input  logic [ledd_pkg::INDEX_W-1:0] pixel_index,
  input  logic [ledd_pkg::CHAN_W-1:0]  red,
  input  logic [ledd_pkg::CHAN_W-1:0]  green,
  input  logic [ledd_pkg::CHAN_W-1:0]  blue,
  input  logic                         start_frame,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic                         serial_out,
  output logic                         busy_res,
  output logic                         frame_done,
  output logic                         write_ignored
);
  import ledd_pkg::*;

  localparam int AW = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;

  cfg_t              cfg;
  logic              clearing;
  logic              q_valid;
  item_t             q_item;
  logic              q_pop;
  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  logic [WORD_W-1:0] mem_wdata;
  logic              mem_re;
  logic [AW-1:0]     mem_raddr;
  logic [WORD_W-1:0] mem_rdata;

  // configuration registers
  ledd_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // input queue
  ledd_front u_front (
    .clk         (clk),
    .rst         (rst),
    .hold        (clearing),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .write_pixel (write_pixel),
    .pixel_index (pixel_index),
    .red         (red),
    .green       (green),
    .blue        (blue),
    .start_frame (start_frame),
    .q_valid     (q_valid),
    .q_item      (q_item),
    .q_pop       (q_pop)
  );

  // pixel store
  ledd_store #(
    .MAX_PIXELS (MAX_PIXELS)
  ) u_store (
    .clk      (clk),
    .rst      (rst),
    .clearing (clearing),
    .we       (mem_we),
    .waddr    (mem_waddr),
    .wdata    (mem_wdata),
    .re       (mem_re),
    .raddr    (mem_raddr),
    .rdata    (mem_rdata)
  );

  // waveform engine
  ledd_engine #(
    .MAX_PIXELS (MAX_PIXELS)
  ) u_engine (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .q_valid       (q_valid),
    .q_item        (q_item),
    .q_pop         (q_pop),
    .mem_we        (mem_we),
    .mem_waddr     (mem_waddr),
    .mem_wdata     (mem_wdata),
    .mem_re        (mem_re),
    .mem_raddr     (mem_raddr),
    .mem_rdata     (mem_rdata),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .serial_out    (serial_out),
    .busy_res      (busy_res),
    .frame_done    (frame_done),
    .write_ignored (write_ignored)
  );

endmodule

`default_nettype wire

[rtl/ledd_regs.sv]
// configuration register file behind the apb-style port
`default_nettype none

module ledd_regs (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [ledd_pkg::PADDR_W-1:0] paddr,
  input  logic [ledd_pkg::PDATA_W-1:0] pwdata,
  output logic [ledd_pkg::PDATA_W-1:0] prdata,
  output logic                         pready,
  output ledd_pkg::cfg_t               cfg
);
  import ledd_pkg::*;

  logic                 wr_en;
  logic [REG_SEL_W-1:0] sel;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign sel    = paddr[PADDR_W-1:2];

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.pixel_count      <= PIXEL_COUNT_RST;
      cfg.one_high_ticks   <= ONE_HIGH_RST;
      cfg.zero_high_ticks  <= ZERO_HIGH_RST;
      cfg.bit_period_ticks <= BIT_PERIOD_RST;
      cfg.latch_ticks      <= LATCH_RST;
    end else if (wr_en) begin
      case (sel)
        REG_PIXEL_COUNT:     cfg.pixel_count      <= pwdata[PIXEL_COUNT_W-1:0];
        REG_ONE_HIGH_TICKS:  cfg.one_high_ticks   <= pwdata[TICKS_W-1:0];
        REG_ZERO_HIGH_TICKS: cfg.zero_high_ticks  <= pwdata[TICKS_W-1:0];
        REG_BIT_PERIOD:      cfg.bit_period_ticks <= pwdata[TICKS_W-1:0];
        REG_LATCH_TICKS:     cfg.latch_ticks      <= pwdata[LATCH_W-1:0];
        default: ;
      endcase
    end
  end

  // readback
  always_comb begin
    case (sel)
      REG_PIXEL_COUNT:     prdata = PDATA_W'(cfg.pixel_count);
      REG_ONE_HIGH_TICKS:  prdata = PDATA_W'(cfg.one_high_ticks);
      REG_ZERO_HIGH_TICKS: prdata = PDATA_W'(cfg.zero_high_ticks);
      REG_BIT_PERIOD:      prdata = PDATA_W'(cfg.bit_period_ticks);
      REG_LATCH_TICKS:     prdata = PDATA_W'(cfg.latch_ticks);
      default:             prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

[rtl/ledd_front.sv]
// input side: accepts tick beats, packs the colour and queues them
`default_nettype none

module ledd_front (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         hold,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         write_pixel,
  input  logic [ledd_pkg::INDEX_W-1:0] pixel_index,
  input  logic [ledd_pkg::CHAN_W-1:0]  red,
  input  logic [ledd_pkg::CHAN_W-1:0]  green,
  input  logic [ledd_pkg::CHAN_W-1:0]  blue,
  input  logic                         start_frame,
  output logic                         q_valid,
  output ledd_pkg::item_t              q_item,
  input  logic                         q_pop
);
  import ledd_pkg::*;

  item_t             entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wptr;
  logic [QPTR_W-1:0] rptr;
  logic [QCNT_W-1:0] fill;
  logic              push;
  item_t             packed_item;

  // stall while the queue is full or the store is being cleared
  assign in_stall = (fill == QCNT_W'(QUEUE_DEPTH)) || hold;
  assign push     = in_valid && !in_stall;
  assign q_valid  = (fill != '0);
  assign q_item   = entries[rptr];

  // classify the beat: colour goes to grb order
  always_comb begin
    packed_item.wr    = write_pixel;
    packed_item.index = pixel_index;
    packed_item.grb   = {green, red, blue};
    packed_item.start = start_frame;
  end

  // queue payload
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wptr] <= packed_item;
    end
  end

  // queue pointers and fill
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      fill <= '0;
    end else begin
      if (push) begin
        wptr <= wptr + 1'b1;
      end
      if (q_pop) begin
        rptr <= rptr + 1'b1;
      end
      case ({push, q_pop})
        2'b10:   fill <= fill + 1'b1;
        2'b01:   fill <= fill - 1'b1;
        default: fill <= fill;
      endcase
    end
  end

endmodule

`default_nettype wire

[rtl/ledd_store.sv]
// pixel store memory with a clearing pass after reset
`default_nettype none

module ledd_store #(
  parameter int MAX_PIXELS = ledd_pkg::MAX_PIXELS_DEF,
  localparam int AW = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1
) (
  input  logic                        clk,
  input  logic                        rst,
  output logic                        clearing,
  input  logic                        we,
  input  logic [AW-1:0]               waddr,
  input  logic [ledd_pkg::WORD_W-1:0] wdata,
  input  logic                        re,
  input  logic [AW-1:0]               raddr,
  output logic [ledd_pkg::WORD_W-1:0] rdata
);
  import ledd_pkg::*;

  logic [WORD_W-1:0] mem [MAX_PIXELS];
  logic [AW-1:0]     clr_addr;
  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  logic [WORD_W-1:0] mem_wdata;

  // clearing pass owns the write port
  assign mem_we    = clearing || we;
  assign mem_waddr = clearing ? clr_addr : waddr;
  assign mem_wdata = clearing ? '0 : wdata;

  // clear sweep, one entry per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      clr_addr <= clr_addr + 1'b1;
      if (clr_addr == AW'(MAX_PIXELS - 1)) begin
        clearing <= 1'b0;
      end
    end
  end

  // write port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
  end

  // registered read with write forwarding
  always_ff @(posedge clk) begin
    if (re) begin
      if (mem_we && (mem_waddr == raddr)) begin
        rdata <= mem_wdata;
      end else begin
        rdata <= mem[raddr];
      end
    end
  end

endmodule

`default_nettype wire

[rtl/ledd_engine.sv]
// back side: runs one waveform tick per queued beat and holds the result
`default_nettype none

module ledd_engine #(
  parameter int MAX_PIXELS = ledd_pkg::MAX_PIXELS_DEF,
  localparam int AW = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1
) (
  input  logic                        clk,
  input  logic                        rst,
  input  ledd_pkg::cfg_t              cfg,
  input  logic                        q_valid,
  input  ledd_pkg::item_t             q_item,
  output logic                        q_pop,
  output logic                        mem_we,
  output logic [AW-1:0]               mem_waddr,
  output logic [ledd_pkg::WORD_W-1:0] mem_wdata,
  output logic                        mem_re,
  output logic [AW-1:0]               mem_raddr,
  input  logic [ledd_pkg::WORD_W-1:0] mem_rdata,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic                        serial_out,
  output logic                        busy_res,
  output logic                        frame_done,
  output logic                        write_ignored
);
  import ledd_pkg::*;

  localparam int CW = $clog2(MAX_PIXELS + 1);
  localparam int XW = (CW > PIXEL_COUNT_W) ? CW : PIXEL_COUNT_W;

  mode_t                mode;
  mode_t                mode_next;
  logic [WORD_W-1:0]    shift_word;
  logic                 use_rd;
  logic [BIT_CNT_W-1:0] bit_counter;
  logic [CW-1:0]        pixel_counter;
  logic [TICKS_W-1:0]   phase_counter;
  logic [LATCH_W-1:0]   gap_counter;

  logic                 tick;
  logic [XW-1:0]        count_x;
  logic [XW-1:0]        cap_x;
  logic [XW-1:0]        lim_x;
  logic [CW-1:0]        ecount;
  logic                 in_range;
  logic                 busy;
  logic [WORD_W-1:0]    cur_word;
  logic [TICKS_W-1:0]   high_ticks;
  logic                 line;
  logic [TICKS_W:0]     phase_inc;
  logic                 phase_wrap;
  logic                 last_bit;
  logic [CW-1:0]        pc_inc;
  logic                 frame_end;
  logic                 go;
  logic [LATCH_W-1:0]   gap_dec;

  // a tick runs when a beat is queued and the output register frees up
  assign tick  = q_valid && (!out_valid || !out_stall);
  assign q_pop = tick;

  // effective count and tick datapath
  always_comb begin
    count_x    = XW'(cfg.pixel_count);
    cap_x      = XW'(MAX_PIXELS);
    lim_x      = (count_x > cap_x) ? cap_x : count_x;
    ecount     = CW'(lim_x);
    in_range   = XW'(q_item.index) < lim_x;
    busy       = (mode != MODE_IDLE);
    cur_word   = use_rd ? mem_rdata : shift_word;
    high_ticks = cur_word[WORD_W-1] ? cfg.one_high_ticks : cfg.zero_high_ticks;
    line       = (mode == MODE_SEND) && (phase_counter < high_ticks);
    phase_inc  = {1'b0, phase_counter} + 1'b1;
    phase_wrap = phase_inc >= {1'b0, cfg.bit_period_ticks};
    last_bit   = bit_counter >= LAST_BIT;
    pc_inc     = pixel_counter + 1'b1;
    frame_end  = (mode == MODE_SEND) && phase_wrap && last_bit && (pc_inc >= ecount);
    go         = (mode == MODE_WAIT) || (q_item.start && (ecount != '0));
    gap_dec    = (gap_counter != '0) ? gap_counter - 1'b1 : gap_counter;
  end

  // store ports: writes only when idle, read ahead the next pixel while sending
  always_comb begin
    mem_we    = tick && q_item.wr && !busy && in_range;
    mem_waddr = AW'(q_item.index);
    mem_wdata = q_item.grb;
    mem_re    = tick;
    mem_raddr = (mode == MODE_SEND) ? AW'(pc_inc) : '0;
  end

  // next mode
  always_comb begin
    mode_next = mode;
    case (mode)
      MODE_IDLE, MODE_WAIT: begin
        if (tick && go) begin
          mode_next = (gap_dec == '0) ? MODE_SEND : MODE_WAIT;
        end
      end
      MODE_SEND: begin
        if (tick && frame_end) begin
          mode_next = MODE_IDLE;
        end
      end
      default: mode_next = MODE_IDLE;
    endcase
  end

  // mode register
  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= MODE_IDLE;
    end else begin
      mode <= mode_next;
    end
  end

  // counters and shift word
  always_ff @(posedge clk) begin
    if (rst) begin
      shift_word    <= '0;
      use_rd        <= 1'b0;
      bit_counter   <= '0;
      pixel_counter <= '0;
      phase_counter <= '0;
      gap_counter   <= '0;
    end else if (tick) begin
      if (mode == MODE_SEND) begin
        if (phase_wrap) begin
          phase_counter <= '0;
          if (last_bit) begin
            bit_counter <= '0;
            if (frame_end) begin
              gap_counter   <= cfg.latch_ticks;
              shift_word    <= '0;
              pixel_counter <= '0;
              use_rd        <= 1'b0;
            end else begin
              // next pixel arrives on the read port
              pixel_counter <= pc_inc;
              use_rd        <= 1'b1;
            end
          end else begin
            bit_counter <= bit_counter + 1'b1;
            shift_word  <= {cur_word[WORD_W-2:0], 1'b0};
            use_rd      <= 1'b0;
          end
        end else begin
          phase_counter <= phase_inc[TICKS_W-1:0];
          shift_word    <= cur_word;
          use_rd        <= 1'b0;
        end
      end else begin
        gap_counter <= gap_dec;
        if (go && (gap_dec == '0)) begin
          pixel_counter <= '0;
          bit_counter   <= '0;
          phase_counter <= '0;
          use_rd        <= 1'b1;
        end
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (tick) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (tick) begin
      serial_out    <= line;
      busy_res      <= busy;
      frame_done    <= frame_end;
      write_ignored <= q_item.wr && (busy || !in_range);
    end
  end

endmodule

`default_nettype wire
